// File: design/fbpa_pkg.sv
// Package for the fixed block pool allocator.
// Holds shared constants (defaults, register map, response status codes) and the sequencer state type.
// No dependencies.
package fbpa_pkg;

   // Default pool size limit and block count after reset
   localparam int MAX_BLOCKS_DEFAULT = 1024;
   localparam int RESET_COUNT        = 1024;

   // Configuration port
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CFG_COUNT_WIDTH = 11;
   localparam logic REG_BLOCK_COUNT = 1'b0;

   // Response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_OOM   = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;
   localparam logic [1:0] STATUS_FREED = 2'd3;

   // Request sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

// File: design/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator with a LIFO free list. Each request word
// allocates a block (pops the free-list head) or frees a given block (pushes
// it back after a range and double-free check) and returns one response word
// with status, granted block and free count. The link/used-mark memory is
// read in the cycle the word is accepted; the pool is updated and the response
// registered in the execute state once no earlier response is held by a stall.
// No new request word is accepted before that. A waiting response does not
// block the next request from entering. Reset and a write
// of block_count take effect at once: there is no memory clearing pass, as
// blocks never handed out since then are tracked by a low-water mark.
// Depends on fbpa_pkg, fbpa_cfg, fbpa_ctrl and fbpa_ram.
module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT,
   localparam int IW = $clog2(MAX_BLOCKS),
   localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [IW-1:0]                       req_block_index,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [IW-1:0]                       rsp_granted_index,
   output logic [CW-1:0]                       rsp_free_count,
   // Configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fbpa_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [fbpa_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [fbpa_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);

   logic [CW-1:0] block_count;
   logic          reinit;

   // Configuration registers
   fbpa_cfg #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_cfg (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .block_count(block_count),
      .reinit     (reinit)
   );

   // Request sequencer with link memory
   fbpa_ctrl #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .block_count      (block_count),
      .reinit           (reinit),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_granted_index(rsp_granted_index),
      .rsp_free_count   (rsp_free_count)
   );

endmodule

// File: design/fbpa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Read data holds while no read is issued. No dependencies.
module fbpa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/fbpa_cfg.sv
// Configuration registers of the block pool allocator (APB-style port).
// Holds the clamped block count and flags a pool re-initialization. Uses fbpa_pkg.
module fbpa_cfg #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT,
   localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fbpa_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [fbpa_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [fbpa_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output logic [CW-1:0]                       block_count,
   output logic                                reinit
);

   localparam int RESET_COUNT_EFF =
      (fbpa_pkg::RESET_COUNT > MAX_BLOCKS) ? MAX_BLOCKS : fbpa_pkg::RESET_COUNT;

   logic [CW-1:0] block_count_ff;
   logic [CW-1:0] block_count_in;
   logic          reinit_ff;
   logic          reg_write;
   logic [fbpa_pkg::CFG_COUNT_WIDTH-1:0] raw_count;

   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite && (paddr[2] == fbpa_pkg::REG_BLOCK_COUNT);
   assign raw_count = pwdata[fbpa_pkg::CFG_COUNT_WIDTH-1:0];

   // Clamp the written count to 1..MAX_BLOCKS
   always_comb begin
      priority if (raw_count == '0) begin
         block_count_in = CW'(1);
      end else if (32'(raw_count) > 32'(MAX_BLOCKS)) begin
         block_count_in = CW'(MAX_BLOCKS);
      end else begin
         block_count_in = CW'(raw_count);
      end
   end

   // Hold the register and pulse re-initialization on a write
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= CW'(RESET_COUNT_EFF);
         reinit_ff      <= 1'b0;
      end else begin
         reinit_ff <= reg_write;
         if (reg_write) begin
            block_count_ff <= block_count_in;
         end
      end
   end

   // Read back
   assign prdata = (paddr[2] == fbpa_pkg::REG_BLOCK_COUNT) ?
                   fbpa_pkg::CSR_DATA_WIDTH'(block_count_ff) : '0;

   assign block_count = block_count_ff;
   assign reinit      = reinit_ff;

endmodule

// File: design/fbpa_ctrl.sv
// Request sequencer of the block pool allocator: free-list head, counters,
// link/used memory and response register. Uses fbpa_pkg and fbpa_ram.
module fbpa_ctrl #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT,
   localparam int IW = $clog2(MAX_BLOCKS),
   localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] block_count,
   input  logic          reinit,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_kind,
   input  logic [IW-1:0] req_block_index,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic [IW-1:0] rsp_granted_index,
   output logic [CW-1:0] rsp_free_count
);

   localparam int RESET_COUNT_EFF =
      (fbpa_pkg::RESET_COUNT > MAX_BLOCKS) ? MAX_BLOCKS : fbpa_pkg::RESET_COUNT;
   // Memory word: {link (block number + 1), used mark}
   localparam int DW = CW + 1;

   fbpa_pkg::state_type state_ff, state_in;

   logic [CW-1:0] head_ff, head_in;
   logic [CW-1:0] free_ff, free_in;
   // Blocks below this mark were never handed out since re-initialization:
   // their memory words are stale and read as link = own index, unused.
   logic [CW-1:0] low_ff, low_in;
   logic          kind_ff;
   logic [IW-1:0] idx_ff;

   logic          rsp_valid_ff;
   logic [1:0]    status_ff, status_in;
   logic [IW-1:0] granted_ff, granted_in;

   logic          accept;
   logic          done;
   logic [CW-1:0] head_dec;
   logic [IW-1:0] blk;
   logic          virgin;
   logic          used_mark;
   logic [CW-1:0] link_next;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [IW-1:0] rd_addr;
   logic [DW-1:0] rd_data;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != fbpa_pkg::ST_IDLE);
   assign done      = (state_ff == fbpa_pkg::ST_EXEC) && !(rsp_valid_ff && rsp_stall);

   assign head_dec = head_ff - CW'(1);
   assign blk      = head_dec[IW-1:0];
   assign virgin   = (head_ff <= low_ff);
   assign link_next = virgin ? head_dec : rd_data[DW-1:1];
   assign used_mark = (CW'(idx_ff) < low_ff) ? 1'b0 : rd_data[0];

   // Issue the memory read for the accepted word
   assign rd_addr = req_kind ? req_block_index : blk;

   fbpa_ram #(
      .WIDTH(DW),
      .DEPTH(MAX_BLOCKS)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Decide the outcome and the write-back
   always_comb begin
      head_in    = head_ff;
      free_in    = free_ff;
      low_in     = low_ff;
      status_in  = fbpa_pkg::STATUS_OK;
      granted_in = '0;
      wr_en      = 1'b0;
      wr_addr    = blk;
      wr_data    = {rd_data[DW-1:1], 1'b1};
      if (!kind_ff) begin
         // Allocate: pop the head
         if (head_ff == '0) begin
            status_in = fbpa_pkg::STATUS_OOM;
         end else begin
            wr_en      = done;
            head_in    = link_next;
            free_in    = free_ff - CW'(1);
            granted_in = blk;
            if (virgin) begin
               low_in = low_ff - CW'(1);
            end
         end
      end else begin
         // Free: check, then push
         wr_addr = idx_ff;
         wr_data = {head_ff, 1'b0};
         priority if (CW'(idx_ff) >= block_count) begin
            status_in = fbpa_pkg::STATUS_RANGE;
         end else if (!used_mark) begin
            status_in = fbpa_pkg::STATUS_FREED;
         end else begin
            wr_en   = done;
            head_in = CW'(idx_ff) + CW'(1);
            free_in = free_ff + CW'(1);
         end
      end
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbpa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = fbpa_pkg::ST_EXEC;
            end
         end
         fbpa_pkg::ST_EXEC: begin
            if (done) begin
               state_in = fbpa_pkg::ST_IDLE;
            end
         end
         default: state_in = fbpa_pkg::ST_IDLE;
      endcase
   end

   // Control state and pool registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbpa_pkg::ST_IDLE;
         head_ff      <= CW'(RESET_COUNT_EFF);
         free_ff      <= CW'(RESET_COUNT_EFF);
         low_ff       <= CW'(RESET_COUNT_EFF);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (reinit) begin
            head_ff <= block_count;
            free_ff <= block_count;
            low_ff  <= block_count;
         end else if (done) begin
            head_ff <= head_in;
            free_ff <= free_in;
            low_ff  <= low_in;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the request and the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         idx_ff  <= req_block_index;
      end
      if (done) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_free_count    = free_ff;

endmodule

// File: tb/sv/fixed_block_pool_allocator_tb.sv
// Self-checking bench for fixed_block_pool_allocator: drives allocate/free words,
// rewrites block_count over the APB-style port and predicts every response word.
// Depends on fbpa_pkg and the allocator RTL.
module fixed_block_pool_allocator_tb;

   localparam int BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT;
   localparam int IDX_W  = $clog2(BLOCKS);
   localparam int CNT_W  = $clog2(BLOCKS + 1);
   localparam int CSR_ADDR_WIDTH  = fbpa_pkg::CSR_ADDR_WIDTH;
   localparam int CSR_DATA_WIDTH  = fbpa_pkg::CSR_DATA_WIDTH;
   localparam int CFG_COUNT_WIDTH = fbpa_pkg::CFG_COUNT_WIDTH;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_BLOCK_COUNT =
      CSR_ADDR_WIDTH'(4 * fbpa_pkg::REG_BLOCK_COUNT);
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_UNMAPPED    =
      CSR_ADDR_WIDTH'(4 * fbpa_pkg::REG_BLOCK_COUNT + 4);

   typedef enum bit {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } req_kind_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      req_kind_type     kind;
      logic [IDX_W-1:0] index;
   } request_type;

   typedef struct {
      logic [1:0]       status;
      logic [IDX_W-1:0] granted;
      logic [CNT_W-1:0] free_count;
   } answer_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = 1'b0;
   logic [IDX_W-1:0] req_block_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [IDX_W-1:0] rsp_granted_index;
   logic [CNT_W-1:0] rsp_free_count;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata, prdata;

   // Pool shadow: links and head hold block number + 1, zero means none
   logic [CNT_W-1:0] pool_size;
   logic [CNT_W-1:0] link_of [BLOCKS];
   bit               in_use  [BLOCKS];
   logic [CNT_W-1:0] stack_top;
   logic [CNT_W-1:0] free_left;
   int               held_blocks[$];

   request_type   pending_words[$];
   answer_type    awaited_answers[$];
   idle_mode_type idle_mode = IDLE_NONE;
   int            mismatches = 0;
   int            cycle_count = 0;
   int            hold_left = 0;
   int            hold_requests = 0;
   int            holds_served = 0;

   fixed_block_pool_allocator #(.MAX_BLOCKS(BLOCKS)) uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Rebuild the free list for a new block count, clamped to 1..BLOCKS
   function automatic void pool_configure(logic [CSR_DATA_WIDTH-1:0] value);
      logic [CFG_COUNT_WIDTH-1:0] raw;
      raw = value[CFG_COUNT_WIDTH-1:0];
      if (raw == 0)
         pool_size = 1;
      else if (raw > BLOCKS)
         pool_size = BLOCKS;
      else
         pool_size = CNT_W'(raw);
      for (int i = 0; i < BLOCKS; i++) begin
         link_of[i] = (i < pool_size) ? CNT_W'(i) : '0;
         in_use[i]  = 1'b0;
      end
      stack_top = pool_size;
      free_left = pool_size;
      held_blocks.delete();
   endfunction

   // Apply one accepted request word to the shadow pool and queue its answer
   function automatic void predict_answer(logic kind, logic [IDX_W-1:0] index);
      answer_type ans;
      int         blk;
      int         hits[$];
      ans.status  = fbpa_pkg::STATUS_OK;
      ans.granted = '0;
      if (kind == KIND_ALLOC) begin
         if (stack_top == 0 || stack_top > pool_size) begin
            ans.status = fbpa_pkg::STATUS_OOM;
         end else begin
            blk = stack_top - 1;
            in_use[blk] = 1'b1;
            stack_top = link_of[blk];
            free_left--;
            ans.granted = IDX_W'(blk);
            held_blocks.push_back(blk);
         end
      end else if (index >= pool_size) begin
         ans.status = fbpa_pkg::STATUS_RANGE;
      end else if (!in_use[index]) begin
         ans.status = fbpa_pkg::STATUS_FREED;
      end else begin
         in_use[index] = 1'b0;
         link_of[index] = stack_top;
         stack_top = CNT_W'(index) + 1'b1;
         free_left++;
         hits = held_blocks.find_first_index(x) with (x == int'(index));
         if (hits.size() != 0)
            held_blocks.delete(hits[0]);
      end
      ans.free_count = free_left;
      awaited_answers.push_back(ans);
   endfunction

   function automatic bit roll_idle(bit single_side);
      if (idle_mode == IDLE_BOTH)
         return $urandom_range(0, 99) < 35;
      if (single_side)
         return $urandom_range(0, 99) < 63;
      return 1'b0;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Drive request words: predict on acceptance, then load the next or go idle
   always @(posedge clock) begin : drive_requests
      request_type word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_answer(req_kind, req_block_index);
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && !roll_idle(idle_mode == IDLE_SENDER)) begin
               word = pending_words.pop_front();
               req_valid       <= 1'b1;
               req_kind        <= word.kind;
               req_block_index <= word.index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Count down a long response hold-off whenever one is requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
      end
   end

   // Stall responses at random or during a hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= (hold_left != 0) || roll_idle(idle_mode == IDLE_RECEIVER);
   end

   // Compare each accepted response word with the oldest prediction
   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: unexpected response, expected none actual status %0d index %0d count %0d",
                     $time, rsp_status, rsp_granted_index, rsp_free_count);
            mismatches++;
         end else begin
            want = awaited_answers.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("granted_index", want.granted, rsp_granted_index);
            check_field("free_count", want.free_count, rsp_free_count);
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_word(req_kind_type kind, int index);
      request_type word;
      word.kind  = kind;
      word.index = IDX_W'(index);
      pending_words.push_back(word);
   endtask

   // Wait until every word is sent and answered, then let the pipeline drain
   task automatic drain();
      while (pending_words.size() != 0 || req_valid || awaited_answers.size() != 0)
         @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Two-phase register write; the shadow pool follows at the write edge
   task automatic csr_write(logic [CSR_ADDR_WIDTH-1:0] addr, logic [CSR_DATA_WIDTH-1:0] value);
      drain();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_BLOCK_COUNT)
         pool_configure(value);
   endtask

   // Mostly allocate and free of held blocks; the rest stray or double frees
   task automatic random_words(idle_mode_type mode, int count);
      int pick;
      @(posedge clock);
      idle_mode <= mode;
      repeat (count) begin
         while (pending_words.size() >= 2)
            @(negedge clock);
         pick = $urandom_range(0, 99);
         if (pick < 50 || (pick < 85 && held_blocks.size() == 0))
            push_word(KIND_ALLOC, $urandom_range(0, BLOCKS - 1));
         else if (pick < 85)
            push_word(KIND_FREE, held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
         else if ($urandom_range(0, 1))
            push_word(KIND_FREE, $urandom_range(0, BLOCKS - 1));
         else
            push_word(KIND_FREE, $urandom_range(0, pool_size < BLOCKS ? pool_size : BLOCKS - 1));
      end
      drain();
   endtask

   initial begin
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      pool_configure(fbpa_pkg::RESET_COUNT);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Full pool after reset: double frees, pops, push back and re-pop
      push_word(KIND_FREE, 0);
      push_word(KIND_FREE, BLOCKS - 1);
      push_word(KIND_ALLOC, 0);
      push_word(KIND_ALLOC, BLOCKS - 1);
      push_word(KIND_FREE, BLOCKS - 1);
      push_word(KIND_ALLOC, 0);
      push_word(KIND_FREE, BLOCKS - 2);
      push_word(KIND_FREE, BLOCKS - 2);
      drain();

      // Tiny pool: run dry, out of range, free and double free
      csr_write(ADDR_BLOCK_COUNT, 3);
      repeat (4) push_word(KIND_ALLOC, 0);
      push_word(KIND_FREE, 3);
      push_word(KIND_FREE, BLOCKS - 1);
      push_word(KIND_FREE, 0);
      push_word(KIND_FREE, 0);
      push_word(KIND_ALLOC, 0);

      // Zero count clamps to one block
      csr_write(ADDR_BLOCK_COUNT, 0);
      push_word(KIND_ALLOC, 0);
      push_word(KIND_ALLOC, 0);
      push_word(KIND_FREE, 1);
      push_word(KIND_FREE, 0);

      // Unmapped register write leaves the pool alone
      csr_write(ADDR_UNMAPPED, 5);
      push_word(KIND_ALLOC, 0);
      push_word(KIND_ALLOC, 0);

      // Oversized counts clamp to the maximum; upper data bits are dropped
      csr_write(ADDR_BLOCK_COUNT, 2047);
      push_word(KIND_ALLOC, 0);
      csr_write(ADDR_BLOCK_COUNT, BLOCKS + 1);
      push_word(KIND_ALLOC, 0);
      csr_write(ADDR_BLOCK_COUNT, 32'hFFFF_F803);
      push_word(KIND_ALLOC, 0);
      drain();

      // Random phases; the first one also backs up the block with a long hold-off
      csr_write(ADDR_BLOCK_COUNT, BLOCKS);
      @(posedge clock);
      hold_requests <= hold_requests + 1;
      random_words(IDLE_NONE, 280);
      csr_write(ADDR_BLOCK_COUNT, 16);
      random_words(IDLE_SENDER, 280);
      csr_write(ADDR_BLOCK_COUNT, 37);
      random_words(IDLE_RECEIVER, 280);
      csr_write(ADDR_BLOCK_COUNT, 6);
      random_words(IDLE_BOTH, 280);

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
design/fbpa_pkg.sv
design/fbpa_ram.sv
design/fbpa_cfg.sv
design/fbpa_ctrl.sv
design/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_tb.sv
